// ===== sv/sorted_array_priority_queue_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SAPQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SAPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	// Request kinds carried on s_tuser
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// Result status carried on m_tuser
	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// Broadcast from the top level to every cell
	typedef struct packed {
		logic                      en;    // a change happens this cycle
		logic                      deq;   // shift toward the head
		logic signed [VALUE_W-1:0] value; // value to insert
	} cell_ctl_t;

endpackage

// ===== sv/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell (
	input  logic                              clk,
	input  spq_pkg::cell_ctl_t                ctl,
	input  logic                              valid,
	input  logic                              left_valid,
	input  logic                              left_gt,
	input  logic signed [spq_pkg::VALUE_W-1:0] left_value,
	input  logic signed [spq_pkg::VALUE_W-1:0] right_value,
	output logic                              gt,
	output logic signed [spq_pkg::VALUE_W-1:0] value,
	output logic signed [spq_pkg::VALUE_W-1:0] value_next
);

	logic signed [spq_pkg::VALUE_W-1:0] value_q;

	// Flag an entry that must make room for the new value
	assign gt = valid && (value_q > ctl.value);

	// Pick the next content: hold, take right, take left or take the new value
	always_comb begin
		value_next = value_q;
		if (ctl.en) begin
			if (ctl.deq) begin
				value_next = right_value;
			end else if (left_gt) begin
				value_next = left_value;
			end else if (gt || (!valid && left_valid)) begin
				value_next = ctl.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_next;
	end

	assign value = value_q;

endmodule

// ===== sv/sorted_array_priority_queue.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Signals                         Payload
// s        in   s_tvalid s_tready s_tdata/user  tdata: value[31:0]; tuser: command
// m        out  m_tvalid m_tready m_tdata/user  tdata: front_value, count; tuser: status
//
// One request per cycle while the output is not stalled: each cell compares
// against the new value and registers its shift on acceptance, so the row of
// cells sets a rate of one request a clock; the result is registered on acceptance.
// Reset clears the entry count and the output valid; cell contents stay undefined.
// A stalled result holds s_tready low until m_tready takes it.

module sorted_array_priority_queue #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic        s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] front_value, [38:32] count, [39] zero
	output logic [1:0]  m_tuser   // [1:0] status
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]                            count_q;
	logic [CW-1:0]                            count_next;
	logic                                     accept;
	logic                                     full;
	logic                                     empty;
	logic [spq_pkg::STATUS_W-1:0]             status;
	spq_pkg::cell_ctl_t                       ctl;
	logic signed [spq_pkg::VALUE_W-1:0]       front;
	logic                                     m_tvalid_q;
	logic [39:0]                              m_tdata_q;
	logic [1:0]                               m_tuser_q;

	logic                                     cell_valid [CAPACITY];
	logic                                     cell_gt    [CAPACITY];
	logic signed [spq_pkg::VALUE_W-1:0]       cell_value [CAPACITY];
	logic signed [spq_pkg::VALUE_W-1:0]       cell_next  [CAPACITY];

	// Accept while the output register is free or being drained
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	// Decide the request outcome and the broadcast control
	always_comb begin
		status     = spq_pkg::STATUS_DONE;
		count_next = count_q;
		ctl.en     = 1'b0;
		ctl.deq    = (s_tuser == spq_pkg::CMD_DEQ);
		ctl.value  = s_tdata;
		if (s_tuser == spq_pkg::CMD_ENQ) begin
			if (full) begin
				status = spq_pkg::STATUS_FULL;
			end else begin
				ctl.en     = accept;
				count_next = count_q + CW'(1);
			end
		end else begin
			if (empty) begin
				status = spq_pkg::STATUS_EMPTY;
			end else begin
				ctl.en     = accept;
				count_next = count_q - CW'(1);
			end
		end
	end

	// Build the row of cells; the head sees a valid, never-greater neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                               l_valid;
		logic                               l_gt;
		logic signed [spq_pkg::VALUE_W-1:0] l_value;
		logic signed [spq_pkg::VALUE_W-1:0] r_value;

		assign cell_valid[i] = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign l_valid = 1'b1;
			assign l_gt    = 1'b0;
			assign l_value = '0;
		end else begin : g_body
			assign l_valid = cell_valid[i-1];
			assign l_gt    = cell_gt[i-1];
			assign l_value = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_value = cell_value[i];
		end else begin : g_inner
			assign r_value = cell_value[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (cell_valid[i]),
			.left_valid (l_valid),
			.left_gt    (l_gt),
			.left_value (l_value),
			.right_value(r_value),
			.gt         (cell_gt[i]),
			.value      (cell_value[i]),
			.value_next (cell_next[i])
		);
	end

	// Report zero as the front of an empty queue
	assign front = (count_next == '0) ? '0 : cell_next[0];

	// Advance the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {1'b0, spq_pkg::COUNT_W'(count_next), front};
			m_tuser_q <= status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== sv/spq_checker.sv =====
`timescale 1ns / 1ps
`include "sorted_array_priority_queue_macros.svh"

module spq_checker #(
	parameter int CAPACITY = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A stalled result stays put
	`SAPQ_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// A dropped enqueue reports a full queue
	`SAPQ_ASSERT_IMPL(a_full_count, m_tvalid && (m_tuser == spq_pkg::STATUS_FULL), m_tdata[38:32] == 7'(CAPACITY), "full status with wrong count")

	// An ignored dequeue reports an empty queue
	`SAPQ_ASSERT_IMPL(a_empty_status, m_tvalid && (m_tuser == spq_pkg::STATUS_EMPTY), (m_tdata[38:32] == 7'd0) && (m_tdata[31:0] == 32'd0), "empty status with stored data")

	// An empty queue shows a zero front
	`SAPQ_ASSERT_IMPL(a_empty_front, m_tvalid && (m_tdata[38:32] == 7'd0) && (CAPACITY < 128), m_tdata[31:0] == 32'd0, "empty queue with nonzero front")

endmodule

bind sorted_array_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
